@@ hw/rtl/stdf_pkg.sv @@
// ---------------------------------------------------------------------------
// stdf_pkg: shared definitions for the syslog tcp deframer
// Widths, character codes, result codes, register indexes and the result
// record that the deframer buffers towards its output channel.
// ---------------------------------------------------------------------------
`default_nettype none

package stdf_pkg;

   // widths of the parse state
   localparam int COUNT_BITS     = 24;
   localparam int LENGTH_BITS    = 16;
   localparam int CMP_BITS       = 32;

   // port widths
   localparam int BYTE_BITS      = 8;
   localparam int MSG_LEN_BITS   = 16;
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int RSP_DATA_BITS  = 32;

   // results per input item
   localparam int MAX_RESULTS    = 3;
   localparam int RES_CNT_BITS   = 2;

   localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

   // characters
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;

   // input kinds
   localparam logic IN_KIND_DATA  = 1'b0;
   localparam logic IN_KIND_CLOSE = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_NOTICE  = 2'd2;
   localparam logic [1:0] KIND_DISCARD = 2'd3;

   // notice codes
   localparam logic [1:0] NOTICE_NONE       = 2'd0;
   localparam logic [1:0] NOTICE_BAD_TERM   = 2'd1;
   localparam logic [1:0] NOTICE_ZERO_COUNT = 2'd2;
   localparam logic [1:0] NOTICE_OVER_MAX   = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_LINE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXTRA_EN    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXTRA_DELIM = 2'd2;

   localparam logic [CFG_BITS-1:0] MAX_LINE_RESET = 16'd2048;

   // parse phase
   typedef enum logic [1:0] {
      PH_START,
      PH_COUNT,
      PH_BODY
   } phase_type;

   // one buffered result
   typedef struct packed {
      logic [1:0]              kind;
      logic [BYTE_BITS-1:0]    data;
      logic [MSG_LEN_BITS-1:0] length;
      logic [1:0]              code;
   } result_type;

   function automatic result_type make_result(
      input logic [1:0]              kind,
      input logic [BYTE_BITS-1:0]    data,
      input logic [MSG_LEN_BITS-1:0] length,
      input logic [1:0]              code
   );
      result_type r;
      r.kind   = kind;
      r.data   = data;
      r.length = length;
      r.code   = code;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/syslog_tcp_deframer_top.sv @@
// ---------------------------------------------------------------------------
// syslog_tcp_deframer_top: syslog over tcp message deframer
// Splits a received byte stream into messages using octet counting or
// delimiter framing and emits payload bytes, message ends and notices.
// ---------------------------------------------------------------------------
// Usage
//   req_ channel: one transaction per received byte (tuser 0) or per
//   end-of-stream close (tuser 1). rsp_ channel: results, tlast set on the
//   last result that one input transaction causes; an input may cause no
//   result at all (count digits, close at start of frame).
//   csr_ port: write max_line (0), extra_delim_enable (1), extra_delim (2)
//   while the block is idle; other indexes are ignored.
// Timing
//   an input enters the input register at its accepting edge, its results
//   are computed and loaded into the result buffer once the buffer is free
//   and the first result is shown from then on. One input per cycle is
//   sustained while each input gives at most one result and rsp_tready is
//   high; an input with k results holds the next one back until the result
//   buffer has sent all k, one result per cycle while rsp_tready is high.
// Reset and stalls
//   reset clears the parse state, the buffers and loads register defaults.
//   when rsp_tready is low the input register and a skid register take up
//   to two more transactions before req_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module syslog_tcp_deframer_top
   import stdf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   // input channel
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [BYTE_BITS-1:0]      req_tdata,   // [7:0] data_byte
   input  wire logic                      req_tuser,   // [0] kind

   // result channel
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,   // [7:0] out_byte,
                                                       // [23:8] msg_length,
                                                       // [25:24] notice_code
   output logic [1:0]                     rsp_tuser,   // [1:0] out_kind
   output logic                           rsp_tlast,

   // configuration port
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]       csr_wdata
);

   // configuration registers
   logic [CFG_BITS-1:0]   max_line_ff;
   logic                  extra_en_ff;
   logic [BYTE_BITS-1:0]  extra_delim_ff;

   // input register and skid register
   logic                  main_valid_ff;
   logic                  main_kind_ff;
   logic [BYTE_BITS-1:0]  main_byte_ff;
   logic                  skid_valid_ff;
   logic                  skid_kind_ff;
   logic [BYTE_BITS-1:0]  skid_byte_ff;

   // parse state
   phase_type             phase_ff;
   phase_type             phase_in;
   logic                  counted_ff;
   logic                  counted_in;
   logic [COUNT_BITS-1:0] octets_ff;
   logic [COUNT_BITS-1:0] octets_in;
   logic [LENGTH_BITS-1:0] length_ff;
   logic [LENGTH_BITS-1:0] length_in;

   // result buffer
   result_type            res_ff [MAX_RESULTS];
   result_type            res_in [MAX_RESULTS];
   logic [RES_CNT_BITS-1:0] cnt_ff;
   logic [RES_CNT_BITS-1:0] cnt_in;
   logic [RES_CNT_BITS-1:0] pos_ff;

   // handshake helpers
   logic                  req_acc;
   logic                  rsp_acc;
   logic                  last_res;
   logic                  buf_free;
   logic                  take;

   // datapath helpers
   logic                  is_digit;
   logic                  is_delim;
   logic [3:0]            digit_val;
   logic [COUNT_BITS+3:0] octets_x10;
   logic [LENGTH_BITS-1:0] lim;
   logic [CMP_BITS-1:0]   lim_wide;
   result_type            cur;

   // handshakes
   assign req_tready = !skid_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign last_res   = (pos_ff == (cnt_ff - RES_CNT_BITS'(1)));
   assign buf_free   = (cnt_ff == '0) || (rsp_acc && last_res);
   assign take       = main_valid_ff && buf_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff    <= MAX_LINE_RESET;
         extra_en_ff    <= 1'b0;
         extra_delim_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAX_LINE:    max_line_ff    <= csr_wdata;
            REG_EXTRA_EN:    extra_en_ff    <= csr_wdata[0];
            REG_EXTRA_DELIM: extra_delim_ff <= csr_wdata[BYTE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // input and skid register control
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= req_acc;
         end
      end else if (req_acc) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   // input and skid register payload
   always_ff @(posedge clock) begin
      if (take && skid_valid_ff) begin
         main_kind_ff <= skid_kind_ff;
         main_byte_ff <= skid_byte_ff;
      end else if (req_acc && (take || !main_valid_ff)) begin
         main_kind_ff <= req_tuser;
         main_byte_ff <= req_tdata;
      end
      if (req_acc && main_valid_ff && !take) begin
         skid_kind_ff <= req_tuser;
         skid_byte_ff <= req_tdata;
      end
   end

   // byte classification and count arithmetic
   assign is_digit   = (main_byte_ff >= CHAR_ZERO) && (main_byte_ff <= CHAR_NINE);
   assign is_delim   = (main_byte_ff == CHAR_LF) ||
                       (extra_en_ff && (main_byte_ff == extra_delim_ff));
   assign digit_val  = 4'(main_byte_ff - CHAR_ZERO);
   assign lim_wide   = (CMP_BITS'(max_line_ff) < CMP_BITS'(LENGTH_MAX)) ?
                       CMP_BITS'(max_line_ff) : CMP_BITS'(LENGTH_MAX);
   assign lim        = LENGTH_BITS'(lim_wide);

   // times ten as shift and add, then the new digit; count starts from zero
   // when the frame opens with this digit
   always_comb begin
      logic [COUNT_BITS+3:0] base;
      base = (phase_ff == PH_START) ? '0 : (COUNT_BITS+4)'(octets_ff);
      octets_x10 = (base << 3) + (base << 1) + (COUNT_BITS+4)'(digit_val);
   end

   // parse step: next state and results of the item in the input register
   always_comb begin
      logic [RES_CNT_BITS-1:0] n;
      n          = '0;
      phase_in   = phase_ff;
      counted_in = counted_ff;
      octets_in  = octets_ff;
      length_in  = length_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_in[i] = '0;
      end

      if (main_kind_ff == IN_KIND_DATA) begin
         // frame start picks the framing mode
         if (phase_in == PH_START) begin
            if (is_digit) begin
               phase_in   = PH_COUNT;
               octets_in  = '0;
               counted_in = 1'b1;
            end else begin
               phase_in   = PH_BODY;
               counted_in = 1'b0;
            end
         end

         if (phase_in == PH_COUNT) begin
            // count digits, saturating
            if (is_digit) begin
               if (octets_x10[COUNT_BITS+3:COUNT_BITS] != '0) begin
                  octets_in = COUNT_MAX;
               end else begin
                  octets_in = octets_x10[COUNT_BITS-1:0];
               end
            end else begin
               // count terminator
               if (main_byte_ff != CHAR_SPACE) begin
                  res_in[n] = make_result(KIND_NOTICE, '0, '0, NOTICE_BAD_TERM);
                  n = n + RES_CNT_BITS'(1);
               end
               if (octets_in == '0) begin
                  res_in[n] = make_result(KIND_NOTICE, '0, '0, NOTICE_ZERO_COUNT);
                  n = n + RES_CNT_BITS'(1);
               end else if (CMP_BITS'(octets_in) > CMP_BITS'(max_line_ff)) begin
                  res_in[n] = make_result(KIND_NOTICE, '0, '0, NOTICE_OVER_MAX);
                  n = n + RES_CNT_BITS'(1);
               end
               phase_in = PH_BODY;
            end
         end else begin
            // message body: forced split at the length limit
            if (length_in >= lim) begin
               res_in[n] = make_result(KIND_END, '0, MSG_LEN_BITS'(length_in),
                                       NOTICE_NONE);
               n = n + RES_CNT_BITS'(1);
               length_in = '0;
            end
            if (is_delim && !counted_in) begin
               res_in[n] = make_result(KIND_END, '0, MSG_LEN_BITS'(length_in),
                                       NOTICE_NONE);
               n = n + RES_CNT_BITS'(1);
               length_in = '0;
               phase_in  = PH_START;
            end else if (length_in < lim) begin
               res_in[n] = make_result(KIND_PAYLOAD, main_byte_ff, '0, NOTICE_NONE);
               n = n + RES_CNT_BITS'(1);
               length_in = length_in + LENGTH_BITS'(1);
            end
            // counted frame ends when its octets run out
            if (counted_in) begin
               if (octets_in <= COUNT_BITS'(1)) begin
                  octets_in = '0;
                  res_in[n] = make_result(KIND_END, '0, MSG_LEN_BITS'(length_in),
                                          NOTICE_NONE);
                  n = n + RES_CNT_BITS'(1);
                  length_in = '0;
                  phase_in  = PH_START;
               end else begin
                  octets_in = octets_in - COUNT_BITS'(1);
               end
            end
         end
      end else begin
         // end of stream: flush or discard a partial frame
         if (phase_ff != PH_START) begin
            res_in[n] = make_result(counted_ff ? KIND_DISCARD : KIND_END, '0,
                                    MSG_LEN_BITS'(length_ff), NOTICE_NONE);
            n = n + RES_CNT_BITS'(1);
         end
         phase_in  = PH_START;
         octets_in = '0;
         length_in = '0;
      end
      cnt_in = n;
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         counted_ff <= 1'b0;
         octets_ff  <= '0;
         length_ff  <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         counted_ff <= counted_in;
         octets_ff  <= octets_in;
         length_ff  <= length_in;
      end
   end

   // result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
      end else if (take) begin
         cnt_ff <= cnt_in;
         pos_ff <= '0;
      end else if (rsp_acc && last_res) begin
         cnt_ff <= '0;
         pos_ff <= '0;
      end else if (rsp_acc) begin
         pos_ff <= pos_ff + RES_CNT_BITS'(1);
      end
   end

   // result buffer payload
   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

   // output selection
   assign cur       = res_ff[pos_ff];
   assign rsp_tuser = cur.kind;
   assign rsp_tdata = {(RSP_DATA_BITS - BYTE_BITS - MSG_LEN_BITS - 2)'(0),
                       cur.code, cur.length, cur.data};
   assign rsp_tlast = last_res;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb: testbench for the syslog tcp deframer
// Drives received bytes and end-of-stream closes into the req_ channel in
// bursts, stalls the rsp_ channel, and checks every result transaction
// field by field against a behavioural deframer kept in step with each
// accepted input. A short directed table comes first, then random phases
// of mostly well-formed framed traffic under several register settings.
// ---------------------------------------------------------------------------
`default_nettype none

module tb
   import stdf_pkg::*;
();

   localparam int HALF_PERIOD  = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_PHASES   = 9;
   localparam int MAX_REPORTS  = 200;

   // one expected result transaction
   typedef struct packed {
      logic [1:0]              kind;
      logic [BYTE_BITS-1:0]    data;
      logic [MSG_LEN_BITS-1:0] length;
      logic [1:0]              code;
      logic                    last;
   } frame_result_type;

   // one input transaction
   typedef struct packed {
      logic                 kind;
      logic [BYTE_BITS-1:0] data;
   } rx_item_type;

   // directed row: n_typed < 0 means the deframer model decides
   typedef struct {
      rx_item_type            item;
      int                     n_typed;
      frame_result_type [2:0] typed;
   } stim_row_type;

   localparam frame_result_type NO_RESULT = '0;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [BYTE_BITS-1:0]      req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [1:0]                rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   // deframer model state and register copies
   phase_type               rx_phase;
   logic                    counted_frame;
   logic [COUNT_BITS-1:0]   octets_due;
   logic [LENGTH_BITS-1:0]  msg_len;
   logic [CFG_BITS-1:0]     cfg_max_line;
   logic                    cfg_extra_en;
   logic [BYTE_BITS-1:0]    cfg_extra_delim;

   frame_result_type due_results [$];
   stim_row_type     directed_rows [$];
   rx_item_type      random_items [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int stall_tick     = 0;
   int stall_mode     = 0;

   // register settings per random phase
   int phase_max_line [NUM_PHASES] = '{2048, 1, 65535, 4, 0, 8, 16, 3, 24};
   int phase_extra_en [NUM_PHASES] = '{0, 1, 1, 0, 1, 1, 1, 1, 0};
   int phase_delim    [NUM_PHASES] = '{8'h00, 8'h00, 8'hFF, 8'h7C, 8'h7C,
                                       8'h3B, 8'h30, 8'h0A, 8'hFF};
   int phase_items    [NUM_PHASES] = '{55, 35, 45, 50, 15, 70, 50, 40, 40};

   syslog_tcp_deframer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic frame_result_type mk_result(input logic [1:0] kind,
                                                  input logic [7:0] data,
                                                  input logic [15:0] length,
                                                  input logic [1:0] code,
                                                  input logic last);
      frame_result_type r;
      r.kind   = kind;
      r.data   = data;
      r.length = length;
      r.code   = code;
      r.last   = last;
      return r;
   endfunction

   // deframer model: one input transaction in, up to three results out
   task automatic deframe_byte(input logic kind, input logic [7:0] c,
                               output frame_result_type [2:0] res, output int n);
      logic        is_digit;
      logic        is_delim;
      logic [63:0] acc;
      res = '0;
      n   = 0;
      if (kind == IN_KIND_CLOSE) begin
         if (rx_phase != PH_START) begin
            res[0] = mk_result(counted_frame ? KIND_DISCARD : KIND_END, 8'h00,
                               msg_len, NOTICE_NONE, 1'b0);
            n = 1;
         end
         rx_phase   = PH_START;
         octets_due = '0;
         msg_len    = '0;
      end else begin
         is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         // first byte of a frame picks the framing
         if (rx_phase == PH_START) begin
            if (is_digit) begin
               rx_phase      = PH_COUNT;
               octets_due    = '0;
               counted_frame = 1'b1;
            end else begin
               rx_phase      = PH_BODY;
               counted_frame = 1'b0;
            end
         end
         if (rx_phase == PH_COUNT) begin
            // count digits, saturating
            if (is_digit) begin
               acc = 64'(octets_due);
               acc = acc * 64'd10 + 64'(c) - 64'(CHAR_ZERO);
               octets_due = (acc > 64'(COUNT_MAX)) ? COUNT_MAX : acc[COUNT_BITS-1:0];
            end else begin
               if (c != CHAR_SPACE) begin
                  res[n] = mk_result(KIND_NOTICE, 8'h00, 16'd0, NOTICE_BAD_TERM, 1'b0);
                  n++;
               end
               if (octets_due == '0) begin
                  res[n] = mk_result(KIND_NOTICE, 8'h00, 16'd0, NOTICE_ZERO_COUNT, 1'b0);
                  n++;
               end else if (octets_due > 24'(cfg_max_line)) begin
                  res[n] = mk_result(KIND_NOTICE, 8'h00, 16'd0, NOTICE_OVER_MAX, 1'b0);
                  n++;
               end
               rx_phase = PH_BODY;
            end
         end else begin
            is_delim = (c == CHAR_LF) || (cfg_extra_en && c == cfg_extra_delim);
            // forced split at the length limit
            if (msg_len >= cfg_max_line) begin
               res[n] = mk_result(KIND_END, 8'h00, msg_len, NOTICE_NONE, 1'b0);
               n++;
               msg_len = '0;
            end
            if (is_delim && !counted_frame) begin
               res[n] = mk_result(KIND_END, 8'h00, msg_len, NOTICE_NONE, 1'b0);
               n++;
               msg_len  = '0;
               rx_phase = PH_START;
            end else if (msg_len < cfg_max_line) begin
               res[n] = mk_result(KIND_PAYLOAD, c, 16'd0, NOTICE_NONE, 1'b0);
               n++;
               msg_len++;
            end
            if (counted_frame) begin
               if (octets_due <= 24'd1) begin
                  octets_due = '0;
                  res[n] = mk_result(KIND_END, 8'h00, msg_len, NOTICE_NONE, 1'b0);
                  n++;
                  msg_len  = '0;
                  rx_phase = PH_START;
               end else begin
                  octets_due--;
               end
            end
         end
      end
      if (n > 0)
         res[n-1].last = 1'b1;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %0s got %0h expected %0h",
                  cycle_count, field, got, want);
   endtask

   // one input transaction, with bursts and gaps on the sending side
   task automatic send_item(input rx_item_type it, input int n_typed,
                            input frame_result_type [2:0] typed);
      frame_result_type [2:0] res;
      int                     n;
      int                     i;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= it.data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      deframe_byte(it.kind, it.data, res, n);
      if (n_typed >= 0) begin
         res = typed;
         n   = n_typed;
      end
      for (i = 0; i < n; i++)
         due_results.push_back(res[i]);
   endtask

   // hold off until every result is in, then let the pipeline settle
   task automatic drain_results;
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [15:0] max_line, input logic extra_en,
                               input logic [7:0] extra_delim);
      csr_we    <= 1'b1;
      csr_index <= REG_MAX_LINE;
      csr_wdata <= max_line;
      @(posedge clock);
      csr_index <= REG_EXTRA_EN;
      csr_wdata <= {15'd0, extra_en};
      @(posedge clock);
      csr_index <= REG_EXTRA_DELIM;
      csr_wdata <= {8'd0, extra_delim};
      @(posedge clock);
      csr_we          <= 1'b0;
      cfg_max_line    = max_line;
      cfg_extra_en    = extra_en;
      cfg_extra_delim = extra_delim;
   endtask

   task automatic add_row(input logic kind, input logic [7:0] data, input int n,
                          input frame_result_type r0, input frame_result_type r1,
                          input frame_result_type r2);
      stim_row_type row;
      row.item    = {kind, data};
      row.n_typed = n;
      row.typed   = {r2, r1, r0};
      directed_rows.push_back(row);
   endtask

   function automatic rx_item_type data_item(input logic [7:0] b);
      return {IN_KIND_DATA, b};
   endfunction

   function automatic rx_item_type close_item();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return {IN_KIND_CLOSE, b};
   endfunction

   function automatic logic [7:0] nondigit_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b >= CHAR_ZERO && b <= CHAR_NINE)
         b = b ^ 8'h40;
      return b;
   endfunction

   // body byte that does not end a delimited frame
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_LF || (cfg_extra_en && b == cfg_extra_delim))
         b = b ^ 8'h40;
      return b;
   endfunction

   // counted body byte, with delimiters mixed in as ordinary payload
   function automatic logic [7:0] counted_byte();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0)
         return CHAR_LF;
      else if (pick == 1)
         return cfg_extra_delim;
      else
         return 8'($urandom_range(0, 255));
   endfunction

   // random phase: mostly well-formed frames, some noise and broken frames
   task automatic build_random(input int budget);
      int pick, cnt, tmp, hi, nbody, i;
      bit cut;
      int digs [$];
      random_items.delete();
      while (random_items.size() < budget) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            // octet counted frame
            if ($urandom_range(0, 15) == 0) begin
               cnt = $urandom_range(0, 99999999);
            end else begin
               hi = cfg_max_line + 4;
               if (hi > 24) hi = 24;
               cnt = $urandom_range(0, hi);
            end
            digs.delete();
            tmp = cnt;
            do begin
               digs.push_front(tmp % 10);
               tmp = tmp / 10;
            end while (tmp > 0);
            if ($urandom_range(0, 5) == 0)
               random_items.push_back(data_item(CHAR_ZERO));
            foreach (digs[i])
               random_items.push_back(data_item(8'(CHAR_ZERO + digs[i])));
            if ($urandom_range(0, 3) != 0)
               random_items.push_back(data_item(CHAR_SPACE));
            else
               random_items.push_back(data_item(nondigit_byte()));
            nbody = (cnt == 0) ? 1 : cnt;
            cut = 1'b0;
            if (nbody > 40) begin
               nbody = $urandom_range(0, 6);
               cut   = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
               nbody = $urandom_range(0, nbody - 1);
               cut   = 1'b1;
            end
            for (i = 0; i < nbody; i++)
               random_items.push_back(data_item(counted_byte()));
            if (cut)
               random_items.push_back(close_item());
         end else if (pick < 8) begin
            // delimiter framed message
            random_items.push_back(data_item(nondigit_byte()));
            hi = cfg_max_line * 2 + 2;
            if (hi > 30) hi = 30;
            nbody = $urandom_range(0, hi);
            for (i = 0; i < nbody; i++)
               random_items.push_back(data_item(plain_byte()));
            if ($urandom_range(0, 7) == 0)
               random_items.push_back(close_item());
            else if (cfg_extra_en && $urandom_range(0, 1) == 1)
               random_items.push_back(data_item(cfg_extra_delim));
            else
               random_items.push_back(data_item(CHAR_LF));
         end else begin
            // noise
            nbody = $urandom_range(1, 3);
            for (i = 0; i < nbody; i++) begin
               if ($urandom_range(0, 3) == 0)
                  random_items.push_back(close_item());
               else
                  random_items.push_back(data_item(8'($urandom_range(0, 255))));
            end
         end
      end
      // leave the parser at start of frame for the next register change
      random_items.push_back(close_item());
   endtask

   // cycle counter and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver stalls, the pattern is picked anew at random periodically
   always @(posedge clock) begin
      stall_tick = stall_tick + 1;
      if (stall_tick % 256 == 0)
         stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (stall_tick % 8 < 5);
      endcase
   end

   // result checker
   always @(posedge clock) begin : rsp_check
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            report_mismatch("unexpected result, tdata", rsp_tdata, 32'd0);
         end else begin
            want = due_results.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("out_kind", 32'(rsp_tuser), 32'(want.kind));
            if (rsp_tdata[7:0] !== want.data)
               report_mismatch("out_byte", 32'(rsp_tdata[7:0]), 32'(want.data));
            if (rsp_tdata[23:8] !== want.length)
               report_mismatch("msg_length", 32'(rsp_tdata[23:8]), 32'(want.length));
            if (rsp_tdata[25:24] !== want.code)
               report_mismatch("notice_code", 32'(rsp_tdata[25:24]), 32'(want.code));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   // stimulus sequence
   initial begin : stimulus
      int p, i;
      rx_phase        = PH_START;
      counted_frame   = 1'b0;
      octets_due      = '0;
      msg_len         = '0;
      cfg_max_line    = MAX_LINE_RESET;
      cfg_extra_en    = 1'b0;
      cfg_extra_delim = 8'h00;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table, register defaults after reset
      add_row(IN_KIND_CLOSE, 8'h00, 0, NO_RESULT, NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, 8'h61, 1,
              mk_result(KIND_PAYLOAD, 8'h61, 16'd0, NOTICE_NONE, 1'b1),
              NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, CHAR_LF, 1,
              mk_result(KIND_END, 8'h00, 16'd1, NOTICE_NONE, 1'b1),
              NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, 8'h35, 0, NO_RESULT, NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, 8'h78, 1,
              mk_result(KIND_NOTICE, 8'h00, 16'd0, NOTICE_BAD_TERM, 1'b1),
              NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, 8'h00, -1, NO_RESULT, NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, 8'hFF, -1, NO_RESULT, NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, CHAR_LF, -1, NO_RESULT, NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, 8'h80, -1, NO_RESULT, NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, 8'h7F, -1, NO_RESULT, NO_RESULT, NO_RESULT);
      // zero count, body of exactly one byte
      add_row(IN_KIND_DATA, CHAR_ZERO, 0, NO_RESULT, NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, CHAR_SPACE, 1,
              mk_result(KIND_NOTICE, 8'h00, 16'd0, NOTICE_ZERO_COUNT, 1'b1),
              NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, 8'hFF, 2,
              mk_result(KIND_PAYLOAD, 8'hFF, 16'd0, NOTICE_NONE, 1'b0),
              mk_result(KIND_END, 8'h00, 16'd1, NOTICE_NONE, 1'b1), NO_RESULT);
      // saturating count, bad terminator and over-max together
      for (i = 0; i < 8; i++)
         add_row(IN_KIND_DATA, CHAR_NINE, 0, NO_RESULT, NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, 8'h3A, 2,
              mk_result(KIND_NOTICE, 8'h00, 16'd0, NOTICE_BAD_TERM, 1'b0),
              mk_result(KIND_NOTICE, 8'h00, 16'd0, NOTICE_OVER_MAX, 1'b1), NO_RESULT);
      // close inside counted and delimited frames
      add_row(IN_KIND_CLOSE, 8'hFF, 1,
              mk_result(KIND_DISCARD, 8'h00, 16'd0, NOTICE_NONE, 1'b1),
              NO_RESULT, NO_RESULT);
      add_row(IN_KIND_DATA, 8'h62, -1, NO_RESULT, NO_RESULT, NO_RESULT);
      add_row(IN_KIND_CLOSE, 8'h00, 1,
              mk_result(KIND_END, 8'h00, 16'd1, NOTICE_NONE, 1'b1),
              NO_RESULT, NO_RESULT);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].n_typed,
                   directed_rows[i].typed);
      drain_results();

      // random phases, each under its own register setting
      for (p = 0; p < NUM_PHASES; p++) begin
         program_regs(16'(phase_max_line[p]), 1'(phase_extra_en[p]),
                      8'(phase_delim[p]));
         build_random(phase_items[p]);
         foreach (random_items[i])
            send_item(random_items[i], -1, '0);
         drain_results();
      end

      if (mismatch_count == 0 && due_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
